// File: hw/rtl/tree_node_registry_defines.svh
// ---------------------------------------------------------------------------
// tree node registry assertion macros
// ---------------------------------------------------------------------------
`ifndef TREE_NODE_REGISTRY_DEFINES_SVH
`define TREE_NODE_REGISTRY_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define TNR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TNR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tnr_pkg.sv
// ---------------------------------------------------------------------------
// tnr_pkg
// shared types and codes for the tree node registry
// ---------------------------------------------------------------------------
package tnr_pkg;

   localparam int OP_BITS     = 2;
   localparam int PARENT_BITS = 10;
   localparam int ID_BITS     = 9;
   localparam int STATUS_BITS = 3;
   localparam int REQ_TAG_BITS = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD    = 2'd0,
      OP_NEW    = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK          = 3'd0,
      ST_ROOT_EXISTS = 3'd1,
      ST_NO_PARENT   = 3'd2,
      ST_NO_ID       = 3'd3,
      ST_FULL        = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MSRCH_RD,
      S_MSRCH_CMP,
      S_DECIDE,
      S_MAP_SHIFT_RD,
      S_MAP_SHIFT_WR,
      S_EDGE_SCAN_RD,
      S_EDGE_SCAN_CMP,
      S_EDGE_SHIFT_RD,
      S_EDGE_SHIFT_WR,
      S_SLOT_RD,
      S_TAG_RD,
      S_RESP
   } state_type;

endpackage

// File: hw/rtl/tree_node_registry.sv
// ---------------------------------------------------------------------------
// tree_node_registry
// node registry with a sorted id map (binary search) and sorted edge list
// ---------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  request  | req_op req_parent_id req_name_tag       | start & !busy
//           | req_lookup_id                           |
//  response | rsp_status rsp_new_id rsp_found_tag     | rsp_valid, one cycle
//
//  one item at a time; busy from accept until the response cycle.
//  lookup: binary search of the id map (read and compare states), then tag read.
//  add: search, then edge scan and shift-insert; ids grow, so the map appends.
//  the response is a one-cycle strobe; the receiver cannot stall it.
//  synchronous reset clears counters; memories need no clearing.
// ---------------------------------------------------------------------------
`include "tree_node_registry_defines.svh"

module tree_node_registry #(
   parameter int MAX_NODES = 256,
   parameter int TAG_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [tnr_pkg::OP_BITS-1:0]          req_op,
   input  logic signed [tnr_pkg::PARENT_BITS-1:0] req_parent_id,
   input  logic [tnr_pkg::REQ_TAG_BITS-1:0]     req_name_tag,
   input  logic [tnr_pkg::ID_BITS-1:0]          req_lookup_id,
   output logic                                 rsp_valid,
   output logic [tnr_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [tnr_pkg::ID_BITS-1:0]          rsp_new_id,
   output logic [tnr_pkg::REQ_TAG_BITS-1:0]     rsp_found_tag
);
   import tnr_pkg::*;

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = AW + 1;
   localparam int IDW = ID_BITS;
   localparam int TSW = (TAG_BITS < REQ_TAG_BITS) ? TAG_BITS : REQ_TAG_BITS;

   // memories
   logic [IDW-1:0]      map_ids   [MAX_NODES];
   logic [AW-1:0]       map_slots [MAX_NODES];
   logic [TAG_BITS-1:0] name_mem  [MAX_NODES];
   logic [IDW-1:0]      edge_par  [MAX_NODES];
   logic [IDW-1:0]      edge_chd  [MAX_NODES];

   state_type state_ff, state_in;

   logic [IDW-1:0] last_id_ff, last_id_in;
   logic [CW-1:0]  node_count_ff, node_count_in;
   logic           root_valid_ff, root_valid_in;
   logic [CW-1:0]  map_count_ff, map_count_in;
   logic [CW-1:0]  edge_count_ff, edge_count_in;

   // request capture
   op_type              op_ff, op_in;
   logic                is_root_ff, is_root_in;
   logic [IDW-1:0]      key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [IDW-1:0]      nid_ff, nid_in;

   // search / shift indices
   logic [CW-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic           found_ff, found_in;
   logic [CW-1:0]  pos_ff, pos_in, idx_ff, idx_in;

   // response
   logic                    rv_ff, rv_in;
   status_type              st_ff, st_in;
   logic [IDW-1:0]          rid_ff, rid_in;
   logic [REQ_TAG_BITS-1:0] rtag_ff, rtag_in;

   // memory ports
   logic [AW-1:0]       map_ra, map_wa, edge_ra, edge_wa, name_ra;
   logic                map_we, map_slot_we, edge_we, name_we;
   logic [IDW-1:0]      map_wid, edge_wp, edge_wc;
   logic [AW-1:0]       map_wslot;
   logic [IDW-1:0]      map_rid, edge_rp, edge_rc;
   logic [AW-1:0]       map_rslot;
   logic [TAG_BITS-1:0] name_rd;

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_ids[map_wa] <= map_wid;
      end
      if (map_we || map_slot_we) begin
         map_slots[map_wa] <= map_wslot;
      end
      map_rid   <= map_ids[map_ra];
      map_rslot <= map_slots[map_ra];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_par[edge_wa] <= edge_wp;
         edge_chd[edge_wa] <= edge_wc;
      end
      edge_rp <= edge_par[edge_ra];
      edge_rc <= edge_chd[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (name_we) begin
         name_mem[node_count_ff[AW-1:0]] <= tag_ff;
      end
      name_rd <= name_mem[name_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_id_ff    <= '0;
         node_count_ff <= '0;
         root_valid_ff <= 1'b0;
         map_count_ff  <= '0;
         edge_count_ff <= '0;
         rv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_id_ff    <= last_id_in;
         node_count_ff <= node_count_in;
         root_valid_ff <= root_valid_in;
         map_count_ff  <= map_count_in;
         edge_count_ff <= edge_count_in;
         rv_ff         <= rv_in;
      end
      op_ff      <= op_in;
      is_root_ff <= is_root_in;
      key_ff     <= key_in;
      tag_ff     <= tag_in;
      nid_ff     <= nid_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      st_ff      <= st_in;
      rid_ff     <= rid_in;
      rtag_ff    <= rtag_in;
   end

   logic full;
   logic [CW-1:0] idx_m1;
   logic edge_before;
   assign full   = (node_count_ff >= CW'(MAX_NODES));
   assign idx_m1 = idx_ff - CW'(1);
   // stored edge sorts below (key, new id)
   assign edge_before = (edge_rp < key_ff) || ((edge_rp == key_ff) && (edge_rc < nid_ff));

   always_comb begin
      state_in      = state_ff;
      last_id_in    = last_id_ff;
      node_count_in = node_count_ff;
      root_valid_in = root_valid_ff;
      map_count_in  = map_count_ff;
      edge_count_in = edge_count_ff;
      op_in = op_ff; is_root_in = is_root_ff; key_in = key_ff; tag_in = tag_ff;
      nid_in = nid_ff; lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff;
      found_in = found_ff; pos_in = pos_ff; idx_in = idx_ff;
      rv_in = 1'b0; st_in = st_ff; rid_in = rid_ff; rtag_in = rtag_ff;
      map_ra = mid_ff[AW-1:0]; map_wa = idx_ff[AW-1:0];
      map_we = 1'b0; map_slot_we = 1'b0; map_wid = map_rid; map_wslot = map_rslot;
      edge_ra = idx_ff[AW-1:0]; edge_wa = idx_ff[AW-1:0]; edge_we = 1'b0;
      edge_wp = edge_rp; edge_wc = edge_rc;
      name_ra = map_rslot; name_we = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = op_type'(req_op);
               is_root_in = req_parent_id[PARENT_BITS-1];
               key_in     = (req_op == OP_LOOKUP) ? req_lookup_id
                                                  : req_parent_id[IDW-1:0];
               tag_in     = TAG_BITS'(req_name_tag[TSW-1:0]);
               lo_in = '0; hi_in = map_count_ff; found_in = 1'b0;
               st_in = ST_OK; rid_in = '0; rtag_in = '0;
               unique case (op_type'(req_op))
                  OP_ADD: state_in = req_parent_id[PARENT_BITS-1] ? S_DECIDE
                                                                  : S_MSRCH_RD;
                  OP_LOOKUP: state_in = S_MSRCH_RD;
                  OP_NEW: state_in = S_DECIDE;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_MSRCH_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
               map_ra   = mid_in[AW-1:0];
               state_in = S_MSRCH_CMP;
            end else begin
               state_in = (op_ff == OP_LOOKUP) ? S_SLOT_RD : S_DECIDE;
            end
         end
         S_MSRCH_CMP: begin
            if (map_rid == key_ff) begin
               found_in = 1'b1;
               state_in = (op_ff == OP_LOOKUP) ? S_SLOT_RD : S_DECIDE;
            end else begin
               if (key_ff < map_rid) hi_in = mid_ff;
               else lo_in = mid_ff + CW'(1);
               state_in = S_MSRCH_RD;
            end
         end
         S_SLOT_RD: begin
            // map_rslot holds the slot read at mid
            if (!found_ff) begin
               st_in = ST_NO_ID; state_in = S_RESP;
            end else begin
               name_ra = map_rslot; state_in = S_TAG_RD;
            end
         end
         S_TAG_RD: begin
            rtag_in  = REQ_TAG_BITS'(name_rd);
            state_in = S_RESP;
         end
         S_DECIDE: begin
            if (op_ff == OP_ADD && is_root_ff && root_valid_ff) begin
               st_in = ST_ROOT_EXISTS; state_in = S_RESP;
            end else if (op_ff == OP_ADD && !is_root_ff && !found_ff) begin
               st_in = ST_NO_PARENT; state_in = S_RESP;
            end else if (full) begin
               st_in = ST_FULL; state_in = S_RESP;
            end else begin
               nid_in = last_id_ff + IDW'(1);
               last_id_in = nid_in;
               rid_in = nid_in;
               name_we = 1'b1;
               // new id exceeds all stored ids: append at the end of the map
               idx_in = map_count_ff;
               map_wa = map_count_ff[AW-1:0];
               map_we = (map_count_ff < CW'(MAX_NODES));
               map_wid = nid_in;
               map_wslot = node_count_ff[AW-1:0];
               if (map_we) map_count_in = map_count_ff + CW'(1);
               node_count_in = node_count_ff + CW'(1);
               if (op_ff == OP_ADD && is_root_ff) begin
                  root_valid_in = 1'b1; state_in = S_RESP;
               end else if (op_ff == OP_ADD && edge_count_ff < CW'(MAX_NODES)) begin
                  pos_in = '0; state_in = S_EDGE_SCAN_RD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_EDGE_SCAN_RD: begin
            if (pos_ff < edge_count_ff) begin
               edge_ra = pos_ff[AW-1:0]; state_in = S_EDGE_SCAN_CMP;
            end else begin
               idx_in = edge_count_ff; state_in = S_EDGE_SHIFT_RD;
            end
         end
         S_EDGE_SCAN_CMP: begin
            if (edge_before) begin
               pos_in = pos_ff + CW'(1); state_in = S_EDGE_SCAN_RD;
            end else begin
               idx_in = edge_count_ff; state_in = S_EDGE_SHIFT_RD;
            end
         end
         S_EDGE_SHIFT_RD: begin
            if (idx_ff > pos_ff) begin
               edge_ra = idx_m1[AW-1:0]; state_in = S_EDGE_SHIFT_WR;
            end else begin
               edge_wa = pos_ff[AW-1:0]; edge_we = 1'b1;
               edge_wp = key_ff; edge_wc = nid_ff;
               edge_count_in = edge_count_ff + CW'(1);
               state_in = S_RESP;
            end
         end
         S_EDGE_SHIFT_WR: begin
            edge_wa = idx_ff[AW-1:0]; edge_we = 1'b1;
            idx_in = idx_m1; state_in = S_EDGE_SHIFT_RD;
         end
         S_MAP_SHIFT_RD, S_MAP_SHIFT_WR: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rv_ff;
   assign rsp_status    = st_ff;
   assign rsp_new_id    = rid_ff;
   assign rsp_found_tag = rtag_ff;

   `TNR_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy,
      "response while busy")
   `TNR_ASSERT_IMP(a_counts, clock, reset, 1'b1,
      (map_count_ff == node_count_ff) && (edge_count_ff <= node_count_ff),
      "table counts disagree")
   `TNR_ASSERT_IMP(a_reject_no_id, clock, reset,
      rsp_valid && (rsp_status != ST_OK), rsp_new_id == '0,
      "rejected item gives an id")
   `TNR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
      "accepted item did not raise busy")

endmodule

// File: bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// drives random and directed requests into the tree node registry and checks
// every response against a behavioral copy of the registry kept in the bench
// ---------------------------------------------------------------------------
module tb;
   import tnr_pkg::*;

   localparam int NODE_LIMIT  = 256;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [ID_BITS-1:0]      new_id;
      logic [REQ_TAG_BITS-1:0] found_tag;
   } reply_type;

   class registry_scoreboard;
      int unsigned last_id;
      int unsigned node_count;
      bit          root_valid;
      logic [REQ_TAG_BITS-1:0] tags[int unsigned];
      reply_type   pending[$];
      int          errors;

      function void clear();
         last_id = 0;
         node_count = 0;
         root_valid = 0;
         tags.delete();
         pending.delete();
         errors = 0;
      endfunction

      // ids only grow and nothing is removed, so the sorted map and the edge
      // list reduce to a set of known ids
      function void note_request(op_type op, logic signed [PARENT_BITS-1:0] parent,
                                 logic [REQ_TAG_BITS-1:0] tag, logic [ID_BITS-1:0] lid);
         reply_type r;
         r = '0;
         r.status = ST_OK;
         case (op)
            OP_ADD: begin
               if (parent < 0) begin
                  if (root_valid) r.status = ST_ROOT_EXISTS;
               end else if (!tags.exists(int'(parent))) begin
                  r.status = ST_NO_PARENT;
               end
               if (r.status == ST_OK && node_count >= NODE_LIMIT) r.status = ST_FULL;
               if (r.status == ST_OK) begin
                  if (parent < 0) root_valid = 1;
                  last_id++;
                  node_count++;
                  tags[last_id] = tag;
                  r.new_id = ID_BITS'(last_id);
               end
            end
            OP_NEW: begin
               if (node_count >= NODE_LIMIT) begin
                  r.status = ST_FULL;
               end else begin
                  last_id++;
                  node_count++;
                  tags[last_id] = tag;
                  r.new_id = ID_BITS'(last_id);
               end
            end
            OP_LOOKUP: begin
               if (tags.exists(int'(lid))) r.found_tag = tags[lid];
               else r.status = ST_NO_ID;
            end
            default: ;
         endcase
         pending.insert(pending.size(), r);
      endfunction

      function void check_reply(reply_type got);
         reply_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response status=%0d new_id=%0d tag=%h",
                     $time, got.status, got.new_id, got.found_tag);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            errors++;
         end
         if (got.new_id !== exp.new_id) begin
            $display("%0t: new_id expected %0d actual %0d", $time, exp.new_id, got.new_id);
            errors++;
         end
         if (got.found_tag !== exp.found_tag) begin
            $display("%0t: found_tag expected %h actual %h", $time, exp.found_tag,
                     got.found_tag);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [OP_BITS-1:0] req_op = '0;
   logic signed [PARENT_BITS-1:0] req_parent_id = '0;
   logic [REQ_TAG_BITS-1:0] req_name_tag = '0;
   logic [ID_BITS-1:0] req_lookup_id = '0;
   logic rsp_valid;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [ID_BITS-1:0] rsp_new_id;
   logic [REQ_TAG_BITS-1:0] rsp_found_tag;

   registry_scoreboard board = new();
   int idle_cycles = 0;

   tree_node_registry u_dut (
      .clock, .reset, .start, .busy,
      .req_op, .req_parent_id, .req_name_tag, .req_lookup_id,
      .rsp_valid, .rsp_status, .rsp_new_id, .rsp_found_tag
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_reply({rsp_status, rsp_new_id, rsp_found_tag});
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // start stays high into the next item when no idle cycles are drawn
   task automatic send_request(op_type op, logic signed [PARENT_BITS-1:0] parent,
                               logic [REQ_TAG_BITS-1:0] tag, logic [ID_BITS-1:0] lid);
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_op <= op;
      req_parent_id <= parent;
      req_name_tag <= tag;
      req_lookup_id <= lid;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(op, parent, tag, lid);
   endtask

   // parent drawn mostly from ids already given out
   function automatic logic signed [PARENT_BITS-1:0] pick_parent();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k == 0) return -$signed(10'($urandom_range(1, 512)));
      if (k == 1) return PARENT_BITS'($urandom_range(0, 511));
      if (board.last_id == 0) return PARENT_BITS'($urandom_range(0, 3));
      return PARENT_BITS'($urandom_range(1, board.last_id + 1));
   endfunction

   function automatic logic [ID_BITS-1:0] pick_lookup();
      if ($urandom_range(0, 4) == 0) return ID_BITS'($urandom_range(0, 511));
      return ID_BITS'($urandom_range(0, board.last_id + 1));
   endfunction

   initial begin
      int n;
      op_type op;
      board.clear();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table cases, root twice, extremes, unused op
      send_request(OP_LOOKUP, 0, 0, 0);
      send_request(OP_LOOKUP, 0, 0, 9'h1ff);
      send_request(OP_ADD, 5, 32'h1234, 0);
      send_request(OP_ADD, 10'sh1ff, 32'h5555_aaaa, 0);
      send_request(OP_ADD, -1, 32'hffff_ffff, 0);
      send_request(OP_ADD, -512, 32'h0, 0);
      send_request(OP_NEW, 0, 32'haaaa_5555, 0);
      send_request(OP_ADD, 1, 32'h0000_0001, 0);
      send_request(OP_ADD, 1, 32'h8000_0000, 0);
      send_request(OP_ADD, 3, 32'hdead_beef, 9'h155);
      send_request(OP_LOOKUP, 0, 0, 1);
      send_request(OP_LOOKUP, 0, 0, 4);
      send_request(OP_LOOKUP, 0, 0, 6);
      send_request(OP_NONE, -1, 32'hffff_ffff, 9'h1ff);
      send_request(OP_LOOKUP, 0, 0, 9'h0aa);

      // random: fills the table, then keeps hitting the full case
      for (n = 0; n < 800; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: op = OP_ADD;
            4, 5: op = OP_NEW;
            6, 7, 8: op = OP_LOOKUP;
            default: op = OP_NONE;
         endcase
         send_request(op, pick_parent(), $urandom(), pick_lookup());
      end
      start <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
